// File: rtl/vat_pkg.sv
// Shared types, constants and saturation helper for the vec3 affine transform block.
package vat_pkg;

   localparam int WORD_W = 32;
   localparam int OPD_W  = WORD_W + 1;
   localparam int PROD_W = OPD_W + WORD_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int LANES  = 3;
   localparam int MAT_DEPTH = 16;
   localparam int IDX_W  = 4;
   localparam int CMD_W  = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD       = 3'd0,
      CMD_POINT      = 3'd1,
      CMD_NORMAL     = 3'd2,
      CMD_INV_POINT  = 3'd3,
      CMD_INV_NORMAL = 3'd4
   } cmd_type;

   typedef logic signed [WORD_W-1:0] matrix_type [MAT_DEPTH];

   typedef struct packed {
      logic ld_prod;
      logic ld_sum;
   } lane_ctl_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic                     sat;
   } sat_type;

   function automatic sat_type sat32(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-WORD_W:0] upper;
      sat_type               r;
      upper = v[ACC_W-1:WORD_W-1];
      if ((upper == '0) || (upper == '1)) begin
         r.value = v[WORD_W-1:0];
         r.sat   = 1'b0;
      end else if (v[ACC_W-1]) begin
         r.value = {1'b1, {(WORD_W-1){1'b0}}};
         r.sat   = 1'b1;
      end else begin
         r.value = {1'b0, {(WORD_W-1){1'b1}}};
         r.sat   = 1'b1;
      end
      return r;
   endfunction

endpackage

// File: rtl/vat_if.sv
// Request and response channel interfaces for the vec3 affine transform block.
interface vat_req_if;
   logic                             valid;
   logic                             ready;
   logic [2:0]                       command;
   logic [3:0]                       coef_index;
   logic signed [31:0]               coef_value;
   logic signed [31:0]               vec_x;
   logic signed [31:0]               vec_y;
   logic signed [31:0]               vec_z;

   modport source (output valid, command, coef_index, coef_value, vec_x, vec_y, vec_z,
                   input ready);
   modport sink   (input valid, command, coef_index, coef_value, vec_x, vec_y, vec_z,
                   output ready);
endinterface

interface vat_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [31:0]               out_x;
   logic signed [31:0]               out_y;
   logic signed [31:0]               out_z;
   logic                             saturated;

   modport source (output valid, out_x, out_y, out_z, saturated, input ready);
   modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

// File: rtl/vat_store.sv
// Sixteen-word matrix register file, cleared at reset, written one word per load.
module vat_store import vat_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_index,
   input  logic signed [WORD_W-1:0] wr_data,
   output matrix_type               mat
);

   matrix_type mat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_DEPTH; i++) begin
            mat_ff[i] <= '0;
         end
      end else if (wr_en) begin
         mat_ff[wr_index] <= wr_data;
      end
   end

   assign mat = mat_ff;

endmodule

// File: rtl/vat_lane.sv
// One output component lane: three products, translation term and full-precision sum.
module vat_lane import vat_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  lane_ctl_type             ctl,
   input  logic signed [OPD_W-1:0]  d0,
   input  logic signed [OPD_W-1:0]  d1,
   input  logic signed [OPD_W-1:0]  d2,
   input  logic signed [WORD_W-1:0] b0,
   input  logic signed [WORD_W-1:0] b1,
   input  logic signed [WORD_W-1:0] b2,
   input  logic signed [WORD_W-1:0] tr,
   output logic signed [ACC_W-1:0]  sum
);

   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [PROD_W-1:0] p0_in, p1_in, p2_in;
   logic signed [ACC_W-1:0]  tr_ff, tr_in;
   logic signed [ACC_W-1:0]  sum_ff, sum_in;

   always_comb begin
      p0_in  = d0 * b0;
      p1_in  = d1 * b1;
      p2_in  = d2 * b2;
      tr_in  = ACC_W'(tr) <<< FRAC_BITS;
      sum_in = ACC_W'(p0_ff) + ACC_W'(p1_ff) + ACC_W'(p2_ff) + tr_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_prod) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         tr_ff <= tr_in;
      end
      if (ctl.ld_sum) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// File: rtl/vec3_affine_transform_top.sv
// Top level of the vec3 affine transform block: operand select, three lanes, merge stage.
// Transforms one 3D Q16.16 vector per cycle while the response side does not stall, by a
// stored 4x4 column-major matrix; a load word writes one matrix word and produces no
// response. Transform words pass through a four-stage pipeline (operand select, multiply,
// sum, shift and saturate). Each stage holds only while the stage after it is full and
// stalled, so a new request word is taken every cycle unless a full pipeline stalls; a
// load reaches the matrix in time for the very next word.
module vec3_affine_transform_top import vat_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   vat_req_if.sink   req_ch,
   vat_rsp_if.source rsp_ch
);

   matrix_type mat;

   logic acc, is_load, is_xform, is_fwd;
   logic ld1, ld2, ld3, ld4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;

   logic signed [WORD_W-1:0] vin   [LANES];
   logic signed [OPD_W-1:0]  d_in  [LANES];
   logic signed [OPD_W-1:0]  d_ff  [LANES];
   logic signed [WORD_W-1:0] b_in  [LANES][LANES];
   logic signed [WORD_W-1:0] b_ff  [LANES][LANES];
   logic signed [WORD_W-1:0] tr_in [LANES];
   logic signed [WORD_W-1:0] tr_ff [LANES];
   logic signed [ACC_W-1:0]  sum   [LANES];
   logic signed [ACC_W-1:0]  shr   [LANES];
   sat_type                  res   [LANES];

   logic signed [WORD_W-1:0] out_ff [LANES];
   logic signed [WORD_W-1:0] out_in [LANES];
   logic                     sat_ff, sat_in;
   lane_ctl_type             lane_ctl;

   assign is_load  = (req_ch.command == CMD_LOAD);
   assign is_xform = (req_ch.command == CMD_POINT) || (req_ch.command == CMD_NORMAL) ||
                     (req_ch.command == CMD_INV_POINT) || (req_ch.command == CMD_INV_NORMAL);
   assign is_fwd   = (req_ch.command == CMD_POINT) || (req_ch.command == CMD_NORMAL);

   // hold a stage only while the next one is full and cannot advance
   assign ld4 = !v4_ff || rsp_ch.ready;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;

   assign req_ch.ready = ld1 && !reset;
   assign acc          = req_ch.valid && req_ch.ready;

   assign lane_ctl.ld_prod = ld2;
   assign lane_ctl.ld_sum  = ld3;

   vat_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (acc && is_load),
      .wr_index (req_ch.coef_index),
      .wr_data  (req_ch.coef_value),
      .mat      (mat)
   );

   always_comb begin
      vin[0] = req_ch.vec_x;
      vin[1] = req_ch.vec_y;
      vin[2] = req_ch.vec_z;
      for (int i = 0; i < LANES; i++) begin
         if (req_ch.command == CMD_INV_POINT) begin
            d_in[i] = OPD_W'(vin[i]) - OPD_W'(mat[12 + i]);
         end else begin
            d_in[i] = OPD_W'(vin[i]);
         end
      end
      for (int j = 0; j < LANES; j++) begin
         for (int i = 0; i < LANES; i++) begin
            b_in[j][i] = is_fwd ? mat[4 * i + j] : mat[4 * j + i];
         end
         tr_in[j] = (req_ch.command == CMD_POINT) ? mat[12 + j] : '0;
      end
   end

   always_comb begin
      v1_in = ld1 ? (acc && is_xform) : v1_ff;
      v2_in = ld2 ? v1_ff : v2_ff;
      v3_in = ld3 ? v2_ff : v3_ff;
      v4_in = ld4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         d_ff  <= d_in;
         b_ff  <= b_in;
         tr_ff <= tr_in;
      end
   end

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      vat_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .ctl   (lane_ctl),
         .d0    (d_ff[0]),
         .d1    (d_ff[1]),
         .d2    (d_ff[2]),
         .b0    (b_ff[j][0]),
         .b1    (b_ff[j][1]),
         .b2    (b_ff[j][2]),
         .tr    (tr_ff[j]),
         .sum   (sum[j])
      );
   end

   // drop fraction bits, clip each lane, merge clip flags
   always_comb begin
      sat_in = 1'b0;
      for (int j = 0; j < LANES; j++) begin
         shr[j]    = sum[j] >>> FRAC_BITS;
         res[j]    = sat32(shr[j]);
         out_in[j] = res[j].value;
         sat_in    = sat_in | res[j].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (ld4) begin
         out_ff <= out_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_ch.valid     = v4_ff;
   assign rsp_ch.out_x     = out_ff[0];
   assign rsp_ch.out_y     = out_ff[1];
   assign rsp_ch.out_z     = out_ff[2];
   assign rsp_ch.saturated = sat_ff;

endmodule

// File: rtl/vat_checker.sv
// Port-level assertions for the vec3 affine transform top level, with its bind.
module vat_checker import vat_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [CMD_W-1:0]         req_command,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [WORD_W-1:0] out_x,
   input logic signed [WORD_W-1:0] out_y,
   input logic signed [WORD_W-1:0] out_z,
   input logic                     saturated
);

   localparam logic signed [WORD_W-1:0] MAX_W = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] MIN_W = {1'b1, {(WORD_W-1){1'b0}}};

   logic xform_acc;

   assign xform_acc = req_valid && req_ready &&
                      ((req_command == CMD_POINT) || (req_command == CMD_NORMAL) ||
                       (req_command == CMD_INV_POINT) || (req_command == CMD_INV_NORMAL));

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_x) && $stable(out_y) &&
                                  $stable(out_z) && $stable(saturated))
      else $error("response word changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("response word too soon after reset");

   a_sat_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && saturated |->
         (out_x == MAX_W) || (out_x == MIN_W) || (out_y == MAX_W) || (out_y == MIN_W) ||
         (out_z == MAX_W) || (out_z == MIN_W))
      else $error("saturated flag without a clipped component");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      xform_acc ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("transform word not delivered four cycles after acceptance");

endmodule

bind vec3_affine_transform_top vat_checker u_vat_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_command (req_ch.command),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .out_x       (rsp_ch.out_x),
   .out_y       (rsp_ch.out_y),
   .out_z       (rsp_ch.out_z),
   .saturated   (rsp_ch.saturated)
);
